// File: src/rtbr_pkg.sv
// Shared constants, types and a helper function for the raster-to-block reorder.
package rtbr_pkg;

    localparam int WORD_W     = 32;
    localparam int BLK_IDX_W  = 19;
    localparam int FRAME_W    = 16;
    localparam int BA_W       = 10;
    localparam int LPF_W      = 12;
    localparam int BAND_W     = LPF_W - 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int DESC_DEPTH = 2;
    localparam int OUT_DEPTH  = 4;

    localparam logic [BA_W-1:0]      BA_RESET            = 10'd480;
    localparam logic [LPF_W-1:0]     LPF_RESET           = 12'd1080;
    localparam logic [LPF_W-1:0]     MIN_LINES           = 12'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_ACROSS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_FRAME = 1'b1;
    localparam logic [1:0]           LAST_ROW            = 2'd3;
    localparam logic [2:0]           LAST_WORD_OF_BLOCK  = 3'd7;

    // One complete band waiting in the line store.
    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [FRAME_W-1:0] frame;
        logic               half;
    } band_desc_t;

    // Where the front end is writing right now.
    typedef struct packed {
        logic in_last_row;
        logic half;
    } front_stat_t;

    // The back end has read every block of a band.
    typedef struct packed {
        logic valid;
        logic half;
    } band_done_t;

    function automatic int eff_blocks(logic [BA_W-1:0] ba, int max_blocks);
        int b;
        b = int'(ba);
        if (b < 1) b = 1;
        if (b > max_blocks) b = max_blocks;
        return b;
    endfunction

endpackage

// File: src/rtbr_queue.sv
// Short queue of band descriptors between the front and back ends.
module rtbr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  rtbr_pkg::band_desc_t wr_desc,
    output logic                full,
    input  logic                rd,
    output rtbr_pkg::band_desc_t rd_desc,
    output logic                empty
);
    import rtbr_pkg::*;

    localparam int PTR_W = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
    localparam int CNT_W = $clog2(DESC_DEPTH + 1);

    band_desc_t         slot_reg [DESC_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (32'(count_reg) == DESC_DEPTH);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_desc = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            tail_next = (32'(tail_reg) == DESC_DEPTH - 1) ? '0 : tail_reg + 1'b1;
        end
        if (do_rd)
        begin
            head_next = (32'(head_reg) == DESC_DEPTH - 1) ? '0 : head_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[tail_reg] <= wr_desc;
        end
    end

endmodule

// File: src/rtbr_front.sv
// Front end: raster position tracking, line store writes and band hand-off.
module rtbr_front #(
    parameter int MAX_BLOCKS_ACROSS = 512
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic [rtbr_pkg::WORD_W-1:0]           pixel_word,
    output logic                                  full,
    input  logic [rtbr_pkg::BA_W-1:0]             blocks_across,
    input  logic [rtbr_pkg::LPF_W-1:0]            lines_per_frame,
    input  logic                                  desc_full,
    output logic                                  desc_push,
    output rtbr_pkg::band_desc_t                  desc,
    output logic                                  wr_en,
    output logic [$clog2(2*MAX_BLOCKS_ACROSS)+2:0] wr_addr,
    output logic [rtbr_pkg::WORD_W-1:0]           wr_data,
    output rtbr_pkg::front_stat_t                 stat,
    output logic [$clog2(MAX_BLOCKS_ACROSS+1)-1:0] emit_cnt0,
    output logic [$clog2(MAX_BLOCKS_ACROSS+1)-1:0] emit_cnt1,
    input  rtbr_pkg::band_done_t                  done
);
    import rtbr_pkg::*;

    localparam int COL_W = $clog2(2 * MAX_BLOCKS_ACROSS);
    localparam int CNT_W = $clog2(MAX_BLOCKS_ACROSS + 1);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [LPF_W-1:0]   line_reg, line_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               half_reg, half_next;
    logic [1:0]         pend_reg, pend_next;
    logic [CNT_W-1:0]   cnt_reg [2];
    logic [CNT_W-1:0]   cnt_next [2];

    logic [CNT_W-1:0]   eff_bw;
    logic [CNT_W:0]     words;
    logic [LPF_W-1:0]   eff_lines;
    logic [1:0]         row;
    logic [BAND_W-1:0]  band;
    logic               full_band;
    logic               emit_now;
    logic               first_emit;
    logic               guard;
    logic               accept;
    logic               line_end;
    logic               frame_end;

    assign eff_bw    = CNT_W'(eff_blocks(blocks_across, MAX_BLOCKS_ACROSS));
    assign words     = {eff_bw, 1'b0};
    assign eff_lines = (lines_per_frame < MIN_LINES) ? MIN_LINES : lines_per_frame;
    assign row       = line_reg[1:0];
    assign band      = line_reg[LPF_W-1:2];
    assign full_band = band < eff_lines[LPF_W-1:2];
    assign emit_now  = col_reg[0] && (row == LAST_ROW) && full_band;
    assign first_emit = emit_now && !pend_reg[half_reg];

    // The first three rows of a band overwrite the half that the back end
    // may still be reading, so wait until that band has drained.
    assign guard     = (row != LAST_ROW) && pend_reg[half_reg];
    assign full      = guard || (first_emit && desc_full);
    assign accept    = push && !full;

    assign line_end  = (32'(col_reg) + 32'd1) >= 32'(words);
    assign frame_end = (32'(line_reg) + 32'd1) >= 32'(eff_lines);

    assign wr_en     = accept;
    assign wr_addr   = {half_reg, row, col_reg};
    assign wr_data   = pixel_word;

    assign desc_push  = accept && first_emit;
    assign desc.band  = band;
    assign desc.frame = frame_reg;
    assign desc.half  = half_reg;

    assign stat.in_last_row = (row == LAST_ROW) && full_band;
    assign stat.half        = half_reg;
    assign emit_cnt0        = cnt_reg[0];
    assign emit_cnt1        = cnt_reg[1];

    always_comb
    begin
        col_next    = col_reg;
        line_next   = line_reg;
        frame_next  = frame_reg;
        half_next   = half_reg;
        pend_next   = pend_reg;
        cnt_next[0] = cnt_reg[0];
        cnt_next[1] = cnt_reg[1];

        if (done.valid)
        begin
            pend_next[done.half] = 1'b0;
        end

        if (accept)
        begin
            if (emit_now)
            begin
                if (first_emit)
                begin
                    pend_next[half_reg] = 1'b1;
                    cnt_next[half_reg]  = CNT_W'(1);
                end
                else
                begin
                    cnt_next[half_reg] = cnt_reg[half_reg] + 1'b1;
                end
            end

            if (line_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    line_next  = '0;
                    frame_next = frame_reg + 1'b1;
                end
                else
                begin
                    line_next = line_reg + 1'b1;
                end
                // Every new band goes to the other half of the line store.
                if (row == LAST_ROW || frame_end)
                begin
                    half_next = !half_reg;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            line_reg   <= '0;
            frame_reg  <= '0;
            half_reg   <= 1'b0;
            pend_reg   <= '0;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            line_reg   <= line_next;
            frame_reg  <= frame_next;
            half_reg   <= half_next;
            pend_reg   <= pend_next;
            cnt_reg[0] <= cnt_next[0];
            cnt_reg[1] <= cnt_next[1];
        end
    end

endmodule

// File: src/rtbr_back.sv
// Back end: line store, block-order read sequencer and result buffer.
module rtbr_back #(
    parameter int MAX_BLOCKS_ACROSS = 512
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [$clog2(2*MAX_BLOCKS_ACROSS)+2:0] wr_addr,
    input  logic [rtbr_pkg::WORD_W-1:0]           wr_data,
    input  logic                                  desc_empty,
    input  rtbr_pkg::band_desc_t                  desc,
    output logic                                  desc_pop,
    input  logic [rtbr_pkg::BA_W-1:0]             blocks_across,
    input  rtbr_pkg::front_stat_t                 stat,
    input  logic [$clog2(MAX_BLOCKS_ACROSS+1)-1:0] emit_cnt0,
    input  logic [$clog2(MAX_BLOCKS_ACROSS+1)-1:0] emit_cnt1,
    output rtbr_pkg::band_done_t                  done,
    input  logic                                  pop,
    output logic                                  empty,
    output logic [rtbr_pkg::WORD_W-1:0]           block_word,
    output logic [rtbr_pkg::BLK_IDX_W-1:0]        block_index,
    output logic [rtbr_pkg::FRAME_W-1:0]          frame_index,
    output logic                                  block_last
);
    import rtbr_pkg::*;

    localparam int COL_W  = $clog2(2 * MAX_BLOCKS_ACROSS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS_ACROSS + 1);
    localparam int ADDR_W = COL_W + 3;
    localparam int MEM_D  = 2 ** ADDR_W;
    localparam int PROD_W = BAND_W + CNT_W;
    localparam int OPTR_W = $clog2(OUT_DEPTH);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    logic [WORD_W-1:0]    mem [MEM_D];

    logic                 busy_reg, busy_next;
    band_desc_t           cur_reg, cur_next;
    logic [CNT_W-1:0]     bx_reg, bx_next;
    logic [2:0]           wsel_reg, wsel_next;

    logic                 rd_valid_reg;
    logic [WORD_W-1:0]    mem_q_reg;
    logic [BLK_IDX_W-1:0] rd_idx_reg;
    logic [FRAME_W-1:0]   rd_frame_reg;
    logic                 rd_last_reg;

    logic [WORD_W-1:0]    ob_word  [OUT_DEPTH];
    logic [BLK_IDX_W-1:0] ob_idx   [OUT_DEPTH];
    logic [FRAME_W-1:0]   ob_frame [OUT_DEPTH];
    logic                 ob_last  [OUT_DEPTH];
    logic [OPTR_W-1:0]    ohead_reg, otail_reg;
    logic [OCNT_W-1:0]    ocount_reg, ocount_next;

    logic [CNT_W-1:0]     eff_bw;
    logic [CNT_W-1:0]     cnt_cur;
    logic                 room;
    logic                 issue;
    logic                 band_finish;
    logic                 front_on_band;
    logic [COL_W-1:0]     rd_col;
    logic [ADDR_W-1:0]    rd_addr;
    logic [PROD_W-1:0]    prod;
    logic [BLK_IDX_W-1:0] idx;
    logic                 ob_rd;

    assign eff_bw  = CNT_W'(eff_blocks(blocks_across, MAX_BLOCKS_ACROSS));
    assign cnt_cur = cur_reg.half ? emit_cnt1 : emit_cnt0;

    // Leave a slot for the read already in flight.
    assign room    = (32'(ocount_reg) + 32'(rd_valid_reg)) < OUT_DEPTH;
    assign issue   = busy_reg && (bx_reg < cnt_cur) && room;

    // The band is complete once every emitted block is read and the front
    // end has left the band's last row.
    assign front_on_band = stat.in_last_row && (stat.half == cur_reg.half);
    assign band_finish   = busy_reg && (bx_reg == cnt_cur) && !front_on_band;

    assign desc_pop   = !busy_reg && !desc_empty;
    assign done.valid = band_finish;
    assign done.half  = cur_reg.half;

    assign rd_col  = COL_W'({bx_reg, wsel_reg[0]});
    assign rd_addr = {cur_reg.half, wsel_reg[2:1], rd_col};
    assign prod    = PROD_W'(cur_reg.band) * PROD_W'(eff_bw);
    assign idx     = BLK_IDX_W'(prod + PROD_W'(bx_reg));

    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        bx_next   = bx_reg;
        wsel_next = wsel_reg;
        if (desc_pop)
        begin
            busy_next = 1'b1;
            cur_next  = desc;
            bx_next   = '0;
            wsel_next = '0;
        end
        else if (band_finish)
        begin
            busy_next = 1'b0;
        end
        else if (issue)
        begin
            wsel_next = wsel_reg + 1'b1;
            if (wsel_reg == LAST_WORD_OF_BLOCK)
            begin
                bx_next = bx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            bx_reg       <= '0;
            wsel_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            bx_reg       <= bx_next;
            wsel_reg     <= wsel_next;
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            mem_q_reg    <= mem[rd_addr];
            rd_idx_reg   <= idx;
            rd_frame_reg <= cur_reg.frame;
            rd_last_reg  <= (wsel_reg == LAST_WORD_OF_BLOCK);
        end
    end

    // Result buffer: absorbs the read latency when the receiver stalls.
    assign empty       = (ocount_reg == '0);
    assign ob_rd       = pop && !empty;
    assign block_word  = ob_word[ohead_reg];
    assign block_index = ob_idx[ohead_reg];
    assign frame_index = ob_frame[ohead_reg];
    assign block_last  = ob_last[ohead_reg];

    always_comb
    begin
        ocount_next = ocount_reg;
        if (rd_valid_reg && !ob_rd)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (ob_rd && !rd_valid_reg)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ohead_reg  <= '0;
            otail_reg  <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (rd_valid_reg)
            begin
                otail_reg <= otail_reg + 1'b1;
            end
            if (ob_rd)
            begin
                ohead_reg <= ohead_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            ob_word[otail_reg]  <= mem_q_reg;
            ob_idx[otail_reg]   <= rd_idx_reg;
            ob_frame[otail_reg] <= rd_frame_reg;
            ob_last[otail_reg]  <= rd_last_reg;
        end
    end

endmodule

// File: src/raster_to_block_reorder.sv
// Raster-to-4x4-block reorder for packed YUV422 frames: top level.
//
// Input channel: push/full with one 32-bit raster word (two pixels) per
// word, in raster order. Result channel: empty/pop; each word carries one
// 32-bit block word, its block index, the frame index and a last-of-block
// flag. Each 4x4 block leaves as 8 words, two per line, top to bottom.
// Configuration: cfg_write/cfg_index/cfg_data, written while the block is idle.
//
// The line store holds two bands of four lines each; the back end reads one
// band's blocks one word per cycle while the result buffer has room, and the
// front end meanwhile writes the next band. The back end issues no read
// while it closes one band or while it fetches the next, and the front end
// waits at the start of a band whose half still holds unread blocks. A
// block's words reach the result buffer through the read register once the
// word completing it is taken, after the descriptor fetch if the back end is
// not yet on that band.
// Reset clears the raster position, frame counter and all queues, and loads
// 480 blocks across and 1080 lines. The store needs no clearing. When the
// receiver stops popping, the result buffer fills, the back end stops, and
// full rises once the front end reaches a half still being read.
module raster_to_block_reorder #(
    parameter int MAX_BLOCKS_ACROSS = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rtbr_pkg::WORD_W-1:0]       pixel_word,
    output logic                              empty,
    input  logic                              pop,
    output logic [rtbr_pkg::WORD_W-1:0]       block_word,
    output logic [rtbr_pkg::BLK_IDX_W-1:0]    block_index,
    output logic [rtbr_pkg::FRAME_W-1:0]      frame_index,
    output logic                              block_last,
    input  logic                              cfg_write,
    input  logic [rtbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rtbr_pkg::*;

    localparam int COL_W  = $clog2(2 * MAX_BLOCKS_ACROSS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS_ACROSS + 1);
    localparam int ADDR_W = COL_W + 3;

    logic [BA_W-1:0]   blocks_across_reg;
    logic [LPF_W-1:0]  lines_per_frame_reg;

    logic              desc_full;
    logic              desc_empty;
    logic              desc_push;
    logic              desc_pop;
    band_desc_t        desc_in;
    band_desc_t        desc_out;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    front_stat_t       stat;
    logic [CNT_W-1:0]  emit_cnt0;
    logic [CNT_W-1:0]  emit_cnt1;
    band_done_t        done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_across_reg   <= BA_RESET;
            lines_per_frame_reg <= LPF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLOCKS_ACROSS:   blocks_across_reg   <= cfg_data[BA_W-1:0];
                REG_LINES_PER_FRAME: lines_per_frame_reg <= cfg_data[LPF_W-1:0];
                default:             ;
            endcase
        end
    end

    rtbr_front #(
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .pixel_word      (pixel_word),
        .full            (full),
        .blocks_across   (blocks_across_reg),
        .lines_per_frame (lines_per_frame_reg),
        .desc_full       (desc_full),
        .desc_push       (desc_push),
        .desc            (desc_in),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .stat            (stat),
        .emit_cnt0       (emit_cnt0),
        .emit_cnt1       (emit_cnt1),
        .done            (done)
    );

    rtbr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (desc_push),
        .wr_desc (desc_in),
        .full    (desc_full),
        .rd      (desc_pop),
        .rd_desc (desc_out),
        .empty   (desc_empty)
    );

    rtbr_back #(
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .desc_empty    (desc_empty),
        .desc          (desc_out),
        .desc_pop      (desc_pop),
        .blocks_across (blocks_across_reg),
        .stat          (stat),
        .emit_cnt0     (emit_cnt0),
        .emit_cnt1     (emit_cnt1),
        .done          (done),
        .pop           (pop),
        .empty         (empty),
        .block_word    (block_word),
        .block_index   (block_index),
        .frame_index   (frame_index),
        .block_last    (block_last)
    );

    // A band is never closed while the front end is still adding blocks to it.
    a_done_after_band: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> !(stat.in_last_row && (stat.half == done.half)))
        else $error("band closed while its last row is still being written");

    // A descriptor is only handed over when the queue has room.
    a_desc_room: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> !desc_full)
        else $error("band descriptor pushed into a full queue");

    // Emitted block counts never exceed MAX_BLOCKS_ACROSS.
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(emit_cnt0) <= MAX_BLOCKS_ACROSS) && (32'(emit_cnt1) <= MAX_BLOCKS_ACROSS))
        else $error("emitted block count beyond line width");

endmodule

// File: dv/raster_to_block_reorder_checker.sv
`timescale 1ns / 1ps
// Checker for the raster-to-block reorder: tracks the raster position and compares block words.
module raster_to_block_reorder_checker #(
    parameter int MAX_BLOCKS_ACROSS = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [rtbr_pkg::WORD_W-1:0]       pixel_word,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [rtbr_pkg::WORD_W-1:0]       block_word,
    input  logic [rtbr_pkg::BLK_IDX_W-1:0]    block_index,
    input  logic [rtbr_pkg::FRAME_W-1:0]      frame_index,
    input  logic                              block_last,
    input  logic                              cfg_write,
    input  logic [rtbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtbr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    import rtbr_pkg::*;

    localparam int LINE_WORDS  = 2 * MAX_BLOCKS_ACROSS;
    localparam int BLOCK_WORDS = 8;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [WORD_W-1:0]    data;
        logic [BLK_IDX_W-1:0] index;
        logic [FRAME_W-1:0]   frame;
        logic                 last;
    } block_word_t;

    // Four lines of the current band, indexed by line within the band and word column.
    logic [WORD_W-1:0] band_lines [4][LINE_WORDS];
    block_word_t       block_words_due [$];
    block_word_t       oldest;

    logic [BA_W-1:0]    blocks_cfg;
    logic [LPF_W-1:0]   lines_cfg;
    int unsigned        col_pos;
    int unsigned        line_pos;
    logic [FRAME_W-1:0] frame_cnt;

    task automatic compare_field(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
        end
    endtask

    // Stores one raster word and queues the block it completes, if any.
    task automatic reorder_word(input logic [WORD_W-1:0] w);
        int unsigned bw;
        int unsigned lines;
        int unsigned col;
        int unsigned row;
        int unsigned bx;
        int unsigned i;
        logic [31:0] idx;
        block_word_t bword;
        bw = (blocks_cfg == '0) ? 1 : int'(blocks_cfg);
        if (bw > MAX_BLOCKS_ACROSS)
            bw = MAX_BLOCKS_ACROSS;
        lines = (lines_cfg < MIN_LINES) ? int'(MIN_LINES) : int'(lines_cfg);
        col = (col_pos < LINE_WORDS) ? col_pos : LINE_WORDS - 1;
        row = line_pos % 4;
        band_lines[row][col] = w;

        // The second word of a block in the band's last line completes it,
        // unless the band is the trailing partial one.
        if ((col % 2 == 1) && (row == int'(LAST_ROW)) && (line_pos / 4 < lines / 4)) begin
            bx = col / 2;
            idx = ((line_pos / 4) * bw + bx) & 32'h7FFFF;
            for (i = 0; i < BLOCK_WORDS; i++) begin
                bword.data  = band_lines[i / 2][bx * 2 + i % 2];
                bword.index = idx[BLK_IDX_W-1:0];
                bword.frame = frame_cnt;
                bword.last  = (i == int'(LAST_WORD_OF_BLOCK));
                block_words_due.push_back(bword);
            end
        end

        if (col_pos + 1 >= 2 * bw) begin
            col_pos = 0;
            if (line_pos + 1 >= lines) begin
                line_pos  = 0;
                frame_cnt = frame_cnt + 1'b1;
            end
            else
            begin
                line_pos = (line_pos + 1) % 4096;
            end
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            block_words_due.delete();
            col_pos     = 0;
            line_pos    = 0;
            frame_cnt   = '0;
            blocks_cfg  = BA_RESET;
            lines_cfg   = LPF_RESET;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (pop && !empty) begin
                if (block_words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: block word %h arrived with none expected, expected none",
                                 $time, block_word);
                end
                else
                begin
                    oldest = block_words_due.pop_front();
                    compare_field("block_word", oldest.data, block_word);
                    compare_field("block_index", 32'(oldest.index), 32'(block_index));
                    compare_field("frame_index", 32'(oldest.frame), 32'(frame_index));
                    compare_field("block_last", 32'(oldest.last), 32'(block_last));
                end
            end

            if (cfg_write) begin
                case (cfg_index)
                    REG_BLOCKS_ACROSS:   blocks_cfg = cfg_data[BA_W-1:0];
                    REG_LINES_PER_FRAME: lines_cfg  = cfg_data[LPF_W-1:0];
                    default: ;
                endcase
            end

            if (push && !full)
                reorder_word(pixel_word);

            outstanding = block_words_due.size();
        end
    end

endmodule

// File: dv/raster_to_block_reorder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the raster-to-block reorder: clock, reset, stimulus and verdict.
module raster_to_block_reorder_tb;
    import rtbr_pkg::*;

    localparam int MAX_BLOCKS    = 512;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 800;
    localparam int MODE_WORDS    = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [WORD_W-1:0]     pixel_word;
    logic                  empty;
    logic                  pop;
    logic [WORD_W-1:0]     block_word;
    logic [BLK_IDX_W-1:0]  block_index;
    logic [FRAME_W-1:0]    frame_index;
    logic                  block_last;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int holds_done     = 0;

    logic [BA_W-1:0]  width_setting  = BA_RESET;
    logic [LPF_W-1:0] height_setting = LPF_RESET;

    raster_to_block_reorder #(
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_word  (pixel_word),
        .empty       (empty),
        .pop         (pop),
        .block_word  (block_word),
        .block_index (block_index),
        .frame_index (frame_index),
        .block_last  (block_last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    raster_to_block_reorder_checker #(
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_word  (pixel_word),
        .empty       (empty),
        .pop         (pop),
        .block_word  (block_word),
        .block_index (block_index),
        .frame_index (frame_index),
        .block_last  (block_last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        pop = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != holds_done) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // The unused upper data bits of the width register get random values.
    task automatic set_geometry(input logic [BA_W-1:0] ba, input logic [LPF_W-1:0] lpf);
        logic [CFG_DATA_W-BA_W-1:0] junk;
        junk = (CFG_DATA_W-BA_W)'($urandom());
        width_setting  = ba;
        height_setting = lpf;
        if ($urandom_range(1)) begin
            write_reg(REG_BLOCKS_ACROSS, {junk, ba});
            write_reg(REG_LINES_PER_FRAME, lpf);
        end
        else
        begin
            write_reg(REG_LINES_PER_FRAME, lpf);
            write_reg(REG_BLOCKS_ACROSS, {junk, ba});
        end
    endtask

    // Entered at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        pixel_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_words(input int n);
        logic [WORD_W-1:0] w;
        repeat (n) begin
            case ($urandom_range(7))
                0:       w = '0;
                1:       w = '1;
                default: w = $urandom();
            endcase
            send_word(w);
        end
    endtask

    function automatic int frame_words();
        int bw;
        int lines;
        bw = (width_setting == '0) ? 1 : int'(width_setting);
        if (bw > MAX_BLOCKS)
            bw = MAX_BLOCKS;
        lines = (height_setting < MIN_LINES) ? int'(MIN_LINES) : int'(height_setting);
        return 2 * bw * lines;
    endfunction

    // Waits until every expected block word has come out, then lets the pipeline settle.
    task automatic drain();
        push <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [WORD_W-1:0] corner_words [8];
        int send_mode [4];
        int recv_mode [4];
        int m;
        int sent;

        corner_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                         32'h0000_FFFF, 32'hFFFF_0000, 32'h8000_0001, 32'h7FFF_FFFE};
        send_mode = '{0, 85, 0, 10};
        recv_mode = '{0, 0, 85, 10};

        rst_n      = 1'b0;
        push       = 1'b0;
        pixel_word = '0;
        cfg_write  = 1'b0;
        cfg_index  = REG_BLOCKS_ACROSS;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero width acts as one block, a height below four as one band.
        set_geometry(10'd0, 12'd2);
        for (m = 0; m < 8; m++)
            send_word(corner_words[m]);
        drain();

        // Two blocks across, five lines: one whole band and a trailing partial line.
        // Part way into the partial line the width shrinks below the current column
        // and the height below the current line, so the next word ends the frame.
        set_geometry(10'd2, 12'd5);
        send_words(18);
        drain();
        set_geometry(10'd1, 12'd4);
        send_words(1);
        drain();

        // Width above the maximum and the tallest frame for a few words, then the
        // width drops under the current column so the first line closes early and
        // the rest of the frame completes one block.
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        set_geometry(10'h3FF, 12'hFFF);
        send_words(6);
        drain();
        set_geometry(10'd1, 12'd4);
        send_words(7);
        drain();

        for (m = 0; m < 4; m++) begin
            send_idle_pct  = send_mode[m];
            recv_stall_pct = recv_mode[m];
            sent = 0;
            while (sent < MODE_WORDS) begin
                set_geometry(BA_W'($urandom_range(3)), LPF_W'($urandom_range(6)));
                send_words(frame_words());
                sent += frame_words();
                drain();
            end
        end

        // Receiver holds off while the sender keeps going, so the input backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_geometry(10'd2, 12'd8);
        hold_reqs++;
        send_words(frame_words() + frame_words() / 2);
        drain();

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
